// ----- rtl/sdsq_pkg.sv -----
// Shared types, constants and config register indexes for the slewed delay snapshot queue.
package sdsq_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;

	localparam logic [15:0] RESET_DELAY_NORMAL = 16'd250;
	localparam logic [15:0] RESET_DELAY_ALT    = 16'd1000;
	localparam logic [15:0] RESET_SLEW_RATE    = 16'd300;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_NORMAL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_ALT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLEW_RATE    = 2'd2;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] rot_x;
		logic [31:0] rot_y;
		logic [31:0] rot_z;
		logic [31:0] fov;
	} snap_t;

	localparam int SNAP_W = $bits(snap_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_MULT,
		ST_SLEW,
		ST_PUSH
	} state_t;

endpackage

// ----- rtl/sdsq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module sdsq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/sdsq_slew.sv -----
// Delay slew unit: registered rate times frame time product, then clamped step toward target.
module sdsq_slew (
	input  logic        clk,
	input  logic        mul_en,
	input  logic [15:0] slew_rate,
	input  logic [15:0] frame_time,
	input  logic [15:0] cur_delay,
	input  logic [15:0] target,
	output logic [15:0] next_delay
);

	logic [31:0] prod_q;
	logic [16:0] up_sum;
	logic [16:0] down_step;
	logic [16:0] room;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= 32'(slew_rate * frame_time);
		end
	end

	always_comb begin
		up_sum    = {1'b0, cur_delay} + {1'b0, prod_q[31:16]};
		down_step = 17'(({1'b0, prod_q} + 33'h0_0000_FFFF) >> 16);
		room      = {1'b0, cur_delay} - {1'b0, target};
		if (cur_delay == target) begin
			next_delay = cur_delay;
		end else if (cur_delay < target) begin
			next_delay = (up_sum > {1'b0, target}) ? target : up_sum[15:0];
		end else begin
			next_delay = (down_step > room) ? target : 16'(cur_delay - down_step[15:0]);
		end
	end

endmodule

// ----- rtl/slewed_delay_snapshot_queue_unit.sv -----
// Top level of the slewed delay snapshot queue: sequencer, queue pointers and output register.
//
// One tick is accepted while in_stall is low and the sequencer is idle. The tick first
// releases expired snapshots from the queue RAM one entry at a time (read, then compare),
// then multiplies slew rate by frame time and steps the delay, then pushes the new snapshot.
// Each released entry takes one ST_READ and one ST_CHECK visit, and one more such pair comes
// when an unexpired entry remains to be checked; the single RAM read port sets the per-entry cost.
// The result beat sits in an output register, so the next tick is taken while it waits;
// the push of a tick holds only while an earlier result has not been taken.
module slewed_delay_snapshot_queue_unit #(
	parameter int QUEUE_DEPTH = sdsq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [sdsq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic [15:0] frame_time,
	input  logic        alt_mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	input  logic signed [31:0] field_of_view,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        out_valid,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [31:0] out_rot_x,
	output logic signed [31:0] out_rot_y,
	output logic signed [31:0] out_rot_z,
	output logic signed [31:0] out_fov
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	sdsq_pkg::state_t state_q, state_d;

	logic [15:0] delay_normal_q;
	logic [15:0] delay_alt_q;
	logic [15:0] slew_rate_q;
	logic [15:0] delay_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	sdsq_pkg::snap_t in_snap_q;
	logic [15:0] frame_time_q;
	logic        alt_mode_q;
	sdsq_pkg::snap_t last_q;
	logic        released_q;

	logic        res_valid_q;
	logic        out_valid_q;
	sdsq_pkg::snap_t out_q;

	sdsq_pkg::snap_t rd_snap;
	logic [sdsq_pkg::SNAP_W-1:0] rd_data;
	logic [15:0] next_delay;
	logic [15:0] target;
	logic        accept;
	logic        hit;
	logic        push_go;
	logic        mul_en;
	logic [PTR_W-1:0] head_next;
	logic [PTR_W-1:0] tail_next;

	assign accept    = in_valid && !in_stall;
	assign rd_snap   = sdsq_pkg::snap_t'(rd_data);
	assign hit       = ({1'b0, rd_snap.stamp} + {17'd0, delay_q}) <= {1'b0, in_snap_q.stamp};
	assign target    = alt_mode_q ? delay_alt_q : delay_normal_q;
	assign push_go   = (state_q == sdsq_pkg::ST_PUSH) && (!res_valid_q || !res_stall);
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;

	sdsq_ram #(
		.WIDTH(sdsq_pkg::SNAP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push_go),
		.waddr(tail_q),
		.wdata(in_snap_q),
		.raddr(head_q),
		.rdata(rd_data)
	);

	sdsq_slew u_slew (
		.clk       (clk),
		.mul_en    (mul_en),
		.slew_rate (slew_rate_q),
		.frame_time(frame_time_q),
		.cur_delay (delay_q),
		.target    (target),
		.next_delay(next_delay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdsq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mul_en   = 1'b0;
		case (state_q)
			sdsq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (count_q != '0) ? sdsq_pkg::ST_READ : sdsq_pkg::ST_MULT;
				end
			end
			sdsq_pkg::ST_READ: begin
				state_d = sdsq_pkg::ST_CHECK;
			end
			sdsq_pkg::ST_CHECK: begin
				state_d = (hit && count_q > CNT_W'(1)) ? sdsq_pkg::ST_READ : sdsq_pkg::ST_MULT;
			end
			sdsq_pkg::ST_MULT: begin
				mul_en  = 1'b1;
				state_d = sdsq_pkg::ST_SLEW;
			end
			sdsq_pkg::ST_SLEW: begin
				state_d = sdsq_pkg::ST_PUSH;
			end
			sdsq_pkg::ST_PUSH: begin
				if (push_go) begin
					state_d = sdsq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdsq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_normal_q <= sdsq_pkg::RESET_DELAY_NORMAL;
			delay_alt_q    <= sdsq_pkg::RESET_DELAY_ALT;
			slew_rate_q    <= sdsq_pkg::RESET_SLEW_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				sdsq_pkg::CFG_DELAY_NORMAL: delay_normal_q <= cfg_data;
				sdsq_pkg::CFG_DELAY_ALT:    delay_alt_q    <= cfg_data;
				sdsq_pkg::CFG_SLEW_RATE:    slew_rate_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			delay_q     <= '0;
			released_q  <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				released_q <= 1'b0;
			end
			if (state_q == sdsq_pkg::ST_CHECK && hit) begin
				released_q <= 1'b1;
				head_q     <= head_next;
				count_q    <= count_q - 1'b1;
			end
			if (state_q == sdsq_pkg::ST_SLEW) begin
				delay_q <= next_delay;
			end
			if (push_go) begin
				tail_q <= tail_next;
				if (count_q == FULL_CNT) begin
					head_q <= head_next;
				end else begin
					count_q <= count_q + 1'b1;
				end
				out_valid_q <= released_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_snap_q    <= '{stamp: now_ms, pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
				rot_x: rot_x, rot_y: rot_y, rot_z: rot_z, fov: field_of_view};
			frame_time_q <= frame_time;
			alt_mode_q   <= alt_mode;
			last_q       <= '0;
		end
		if (state_q == sdsq_pkg::ST_CHECK && hit) begin
			last_q <= rd_snap;
		end
		if (push_go) begin
			out_q <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign out_valid = out_valid_q;
	assign out_pos_x = out_q.pos_x;
	assign out_pos_y = out_q.pos_y;
	assign out_pos_z = out_q.pos_z;
	assign out_rot_x = out_q.rot_x;
	assign out_rot_y = out_q.rot_y;
	assign out_rot_z = out_q.rot_z;
	assign out_fov   = out_q.fov;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == FULL_CNT) |-> head_q == tail_q)
		else $error("head and tail disagree with count");

	a_result_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == sdsq_pkg::ST_PUSH))
		else $error("result beat raised outside push");

	a_release_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdsq_pkg::ST_READ) |-> count_q != '0)
		else $error("queue read while empty");

endmodule
